FILE: src/lmtc_pkg.sv
// lcd mode timing controller: shared types and timing constants
// used by lmtc_step and lcd_mode_timing_controller_top; no dependencies
`default_nettype none

package lmtc_pkg;

   // lcd mode codes as seen on the status register
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   localparam int unsigned COUNT_W = 10;
   localparam int unsigned LINE_W  = 8;

   localparam logic [COUNT_W-1:0] HBLANK_CYCLES      = 10'd204;
   localparam logic [COUNT_W-1:0] VBLANK_LINE_CYCLES = 10'd456;
   localparam logic [COUNT_W-1:0] OAM_CYCLES         = 10'd80;
   localparam logic [COUNT_W-1:0] XFER_CYCLES        = 10'd172;
   localparam logic [LINE_W-1:0]  FIRST_VBLANK_LINE  = 8'd144;
   localparam logic [LINE_W-1:0]  LAST_LINE          = 8'd153;

   typedef struct packed {
      mode_type            mode;
      logic [LINE_W-1:0]   line;
      logic [COUNT_W-1:0]  count;
   } timing_state_type;

   typedef struct packed {
      logic vblank_entered;
      logic vblank_irq;
      logic stat_irq;
      logic render_line;
   } event_flags_type;

endpackage

`default_nettype wire

FILE: src/lmtc_step.sv
// lcd mode timing controller: next-state and event logic for one tick
// depends on lmtc_pkg
`default_nettype none

module lmtc_step (
   input  lmtc_pkg::timing_state_type state_cur,
   input  logic [7:0]                 cycles,
   input  logic                       display_enable,
   input  logic                       irq_master_enable,
   input  logic                       vblank_irq_enable,
   input  logic [7:0]                 line_compare,
   output lmtc_pkg::timing_state_type state_nxt,
   output lmtc_pkg::event_flags_type  flags
);
   import lmtc_pkg::*;

   logic [COUNT_W-1:0] count_sum;
   logic [LINE_W-1:0]  line_inc;
   logic               changed;

   assign count_sum = state_cur.count + {{(COUNT_W-8){1'b0}}, cycles};
   assign line_inc  = state_cur.line + 8'd1;

   always_comb begin
      state_nxt = state_cur;
      flags     = '0;
      changed   = 1'b0;
      if (display_enable) begin
         state_nxt.count = count_sum;
         unique case (state_cur.mode)
            MODE_HBLANK: begin
               if (count_sum >= HBLANK_CYCLES) begin
                  state_nxt.count = '0;
                  state_nxt.line  = line_inc;
                  if (line_inc == FIRST_VBLANK_LINE) begin
                     state_nxt.mode       = MODE_VBLANK;
                     flags.vblank_entered = 1'b1;
                  end else begin
                     state_nxt.mode = MODE_OAM;
                  end
                  changed = 1'b1;
               end
            end
            MODE_VBLANK: begin
               if (count_sum >= VBLANK_LINE_CYCLES) begin
                  flags.vblank_irq = (state_cur.line == FIRST_VBLANK_LINE) &&
                                     irq_master_enable && vblank_irq_enable;
                  state_nxt.count = '0;
                  state_nxt.line  = line_inc;
                  // wrap back to the top of the frame
                  if (line_inc > LAST_LINE) begin
                     state_nxt.line = '0;
                     state_nxt.mode = MODE_OAM;
                     changed        = 1'b1;
                  end
               end
            end
            MODE_OAM: begin
               if (count_sum >= OAM_CYCLES) begin
                  state_nxt.count = '0;
                  state_nxt.mode  = MODE_XFER;
                  changed         = 1'b1;
               end
            end
            MODE_XFER: begin
               if (count_sum >= XFER_CYCLES) begin
                  state_nxt.count   = '0;
                  state_nxt.mode    = MODE_HBLANK;
                  flags.render_line = 1'b1;
                  changed           = 1'b1;
               end
            end
            default: begin
               state_nxt = state_cur;
            end
         endcase
         // compare uses the line after the update
         flags.stat_irq = changed && (state_nxt.line == line_compare);
      end
   end

endmodule

`default_nettype wire

FILE: src/lcd_mode_timing_controller_top.sv
// lcd mode timing controller top level: handshakes, timing state, result register
// depends on lmtc_pkg and lmtc_step
`default_nettype none

// usage
//  - req channel: one transaction is one tick carrying the cpu cycles spent
//    since the previous tick plus the display and interrupt enable bits
//  - rsp channel: exactly one transaction per accepted tick, in order, with the
//    lcd mode and scanline after the tick and the event flags it caused
//  - csr port: csr_wr_en writes csr_wr_data into the line compare register;
//    write it only while no tick is in flight
//  - result: a tick's result is registered and is on rsp the cycle after acceptance
//  - throughput: one tick per cycle while req_stall is low; the update is a 10-bit
//    add and a threshold compare from the timing state registers into the result register
//  - stall: a full result register holds while rsp_stall is high; req_stall
//    rises only when that register is full and stalled, and drops the cycle it
//    is taken, so ticks keep flowing back to back
//  - reset: mode hblank, line 0, cycle count 0, line compare 0, rsp empty
//  - display off: the tick still gives a result, with the held mode and line
//    and all event flags low; no state moves

module lcd_mode_timing_controller_top (
   input  logic       clock,
   input  logic       reset,
   // tick input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_cycles,
   input  logic       req_display_enable,
   input  logic       req_irq_master_enable,
   input  logic       req_vblank_irq_enable,
   // result output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_lcd_mode,
   output logic [7:0] rsp_scan_line,
   output logic       rsp_vblank_entered,
   output logic       rsp_vblank_irq,
   output logic       rsp_stat_irq,
   output logic       rsp_render_line,
   // line compare register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import lmtc_pkg::*;

   // timing state and config
   timing_state_type  state_ff, state_in;
   logic [7:0]        compare_ff, compare_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   timing_state_type  rsp_state_ff, rsp_state_in;
   event_flags_type   rsp_flags_ff, rsp_flags_in;

   timing_state_type  step_state;
   event_flags_type   step_flags;
   logic              req_accept;

   lmtc_step u_step (
      .state_cur         (state_ff),
      .cycles            (req_cycles),
      .display_enable    (req_display_enable),
      .irq_master_enable (req_irq_master_enable),
      .vblank_irq_enable (req_vblank_irq_enable),
      .line_compare      (compare_ff),
      .state_nxt         (step_state),
      .flags             (step_flags)
   );

   // hold off new ticks only when the result register cannot drain
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      compare_in   = compare_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_state_in = rsp_state_ff;
      rsp_flags_in = rsp_flags_ff;

      if (csr_wr_en) begin
         compare_in = csr_wr_data;
      end

      if (req_accept) begin
         state_in     = step_state;
         rsp_valid_in = 1'b1;
         rsp_state_in = step_state;
         rsp_flags_in = step_flags;
      end else if (!rsp_stall) begin
         // result taken, nothing new behind it
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode  <= MODE_HBLANK;
         state_ff.line  <= '0;
         state_ff.count <= '0;
         compare_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         compare_ff     <= compare_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_state_ff <= rsp_state_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lcd_mode       = rsp_state_ff.mode;
   assign rsp_scan_line      = rsp_state_ff.line;
   assign rsp_vblank_entered = rsp_flags_ff.vblank_entered;
   assign rsp_vblank_irq     = rsp_flags_ff.vblank_irq;
   assign rsp_stat_irq       = rsp_flags_ff.stat_irq;
   assign rsp_render_line    = rsp_flags_ff.render_line;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for lcd_mode_timing_controller_top: drives cpu ticks, predicts
// mode, line and event flags per tick, checks every result transaction in order
// depends on lmtc_pkg and the rtl under src

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lmtc_pkg::*;

   // a tick as offered on the req channel
   typedef struct packed {
      logic [7:0] cycles;
      logic       display_en;
      logic       ime;
      logic       vbl_ie;
   } tick_type;

   // lcd status expected back for one tick
   typedef struct packed {
      mode_type   mode;
      logic [7:0] line;
      logic       vblank_entered;
      logic       vblank_irq;
      logic       stat_irq;
      logic       render_line;
   } lcd_status_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_cycles = '0;
   logic       req_display_enable = 1'b0;
   logic       req_irq_master_enable = 1'b0;
   logic       req_vblank_irq_enable = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_lcd_mode;
   logic [7:0] rsp_scan_line;
   logic       rsp_vblank_entered;
   logic       rsp_vblank_irq;
   logic       rsp_stat_irq;
   logic       rsp_render_line;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // ticks waiting for the driver, and status waiting for the monitor
   tick_type       tick_backlog[$];
   lcd_status_type pending_status[$];

   // bench copy of the timing state and the line compare register
   mode_type   tm_mode;
   logic [7:0] tm_line;
   logic [9:0] tm_count;
   logic [7:0] tm_compare;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int ticks_queued = 0;
   int ticks_accepted = 0;
   int ticks_dark = 0;
   int results_seen = 0;
   int error_count = 0;
   int frame_wraps = 0;
   int vblank_irqs = 0;
   int stat_irqs = 0;
   int lines_rendered = 0;
   int compare_writes = 0;

   lcd_mode_timing_controller_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cycles            (req_cycles),
      .req_display_enable    (req_display_enable),
      .req_irq_master_enable (req_irq_master_enable),
      .req_vblank_irq_enable (req_vblank_irq_enable),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_lcd_mode          (rsp_lcd_mode),
      .rsp_scan_line         (rsp_scan_line),
      .rsp_vblank_entered    (rsp_vblank_entered),
      .rsp_vblank_irq        (rsp_vblank_irq),
      .rsp_stat_irq          (rsp_stat_irq),
      .rsp_render_line       (rsp_render_line),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always #5 clock = ~clock;

   // advance the bench timing state by one tick and return the status it leaves
   function automatic lcd_status_type advance_timing(input tick_type t);
      lcd_status_type r;
      logic           changed;
      r = '0;
      changed = 1'b0;
      if (t.display_en) begin
         // excess cycles past a threshold are dropped, counter wraps at 10 bits
         tm_count = tm_count + {2'b00, t.cycles};
         case (tm_mode)
            MODE_HBLANK: begin
               if (tm_count >= HBLANK_CYCLES) begin
                  tm_count = '0;
                  tm_line = tm_line + 8'd1;
                  if (tm_line == FIRST_VBLANK_LINE) begin
                     tm_mode = MODE_VBLANK;
                     r.vblank_entered = 1'b1;
                  end else begin
                     tm_mode = MODE_OAM;
                  end
                  changed = 1'b1;
               end
            end
            MODE_VBLANK: begin
               if (tm_count >= VBLANK_LINE_CYCLES) begin
                  // irq fires when the first vblank line ends, not on entry
                  if (tm_line == FIRST_VBLANK_LINE && t.ime && t.vbl_ie)
                     r.vblank_irq = 1'b1;
                  tm_count = '0;
                  tm_line = tm_line + 8'd1;
                  // line steps inside vblank are no mode change
                  if (tm_line > LAST_LINE) begin
                     tm_line = '0;
                     tm_mode = MODE_OAM;
                     changed = 1'b1;
                     frame_wraps++;
                  end
               end
            end
            MODE_OAM: begin
               if (tm_count >= OAM_CYCLES) begin
                  tm_count = '0;
                  tm_mode = MODE_XFER;
                  changed = 1'b1;
               end
            end
            default: begin
               if (tm_count >= XFER_CYCLES) begin
                  tm_count = '0;
                  tm_mode = MODE_HBLANK;
                  r.render_line = 1'b1;
                  changed = 1'b1;
               end
            end
         endcase
         // the wrap compares against line 0 since tm_line is already cleared
         if (changed && tm_line == tm_compare)
            r.stat_irq = 1'b1;
      end
      r.mode = tm_mode;
      r.line = tm_line;
      vblank_irqs += r.vblank_irq;
      stat_irqs += r.stat_irq;
      lines_rendered += r.render_line;
      return r;
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // driver: predicts on every accepted tick, then offers the next one from the backlog
   always @(posedge clock) begin
      tick_type taken;
      tick_type nxt;
      int       send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         tm_mode = MODE_HBLANK;
         tm_line = '0;
         tm_count = '0;
         tm_compare = '0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            taken = {req_cycles, req_display_enable, req_irq_master_enable,
                     req_vblank_irq_enable};
            pending_status.insert(pending_status.size(), advance_timing(taken));
            ticks_accepted++;
            if (!taken.display_en)
               ticks_dark++;
         end
         // a stalled transaction keeps its payload
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_backlog.size() > 0) begin
               nxt = tick_backlog.pop_front();
               req_valid <= 1'b1;
               req_cycles <= nxt.cycles;
               req_display_enable <= nxt.display_en;
               req_irq_master_enable <= nxt.ime;
               req_vblank_irq_enable <= nxt.vbl_ie;
               if ($urandom_range(0, 99) < send_idle_pct)
                  send_gap = $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transaction, stalls in bursts and now and then
   // holds off long enough for the block to back up into req_stall
   always @(posedge clock) begin
      lcd_status_type want;
      logic           nxt_stall;
      int             stall_left;
      int             hold_left;
      int             holds_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         holds_done = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_status.size() == 0) begin
               $error("result with no tick outstanding: mode %0d line %0d",
                      rsp_lcd_mode, rsp_scan_line);
               error_count++;
            end else begin
               want = pending_status.pop_front();
               compare_field("lcd_mode", want.mode, rsp_lcd_mode);
               compare_field("scan_line", want.line, rsp_scan_line);
               compare_field("vblank_entered", want.vblank_entered, rsp_vblank_entered);
               compare_field("vblank_irq", want.vblank_irq, rsp_vblank_irq);
               compare_field("stat_irq", want.stat_irq, rsp_stat_irq);
               compare_field("render_line", want.render_line, rsp_render_line);
            end
         end
         if (holds_done < 2 && results_seen >= 400 * (holds_done + 1)) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         nxt_stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 5) - 1;
            nxt_stall = 1'b1;
         end
         rsp_stall <= nxt_stall;
      end
   end

   // watchdog: a stretch without a transaction on either channel that reaches WATCHDOG_LIMIT ends the run
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("lcd_mode_timing_controller_top test failed");
            $finish;
         end
      end
   end

   task automatic push_tick(input logic [7:0] cyc, input logic en, input logic ime,
                            input logic ie);
      tick_type t;
      t = {cyc, en, ime, ie};
      tick_backlog.insert(tick_backlog.size(), t);
      ticks_queued++;
   endtask

   // block is idle once every queued tick is taken and every result is back
   task automatic wait_drained();
      while (ticks_accepted != ticks_queued || pending_status.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_compare(input logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tm_compare = value;
      compare_writes++;
   endtask

   // mostly large cycle counts so frames go by quickly, with threshold values mixed in
   function automatic tick_type random_tick();
      tick_type t;
      case ($urandom_range(0, 9))
         0, 1: t.cycles = $urandom_range(0, 255);
         2: begin
            case ($urandom_range(0, 5))
               0: t.cycles = 8'd0;
               1: t.cycles = 8'd255;
               2: t.cycles = OAM_CYCLES[7:0];
               3: t.cycles = XFER_CYCLES[7:0];
               4: t.cycles = HBLANK_CYCLES[7:0];
               default: t.cycles = 8'd1;
            endcase
         end
         default: t.cycles = $urandom_range(150, 255);
      endcase
      t.display_en = ($urandom_range(0, 9) != 0);
      t.ime = ($urandom_range(0, 3) != 0);
      t.vbl_ie = ($urandom_range(0, 3) != 0);
      return t;
   endfunction

   initial begin
      logic [7:0] cmp;
      tick_type   t;
      int         lit;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: compare on line 1 so the early mode changes raise stat
      write_compare(8'd1);
      send_idle_pct = 30;
      recv_idle_pct = 30;
      @(negedge clock);
      push_tick(8'd0, 1'b1, 1'b1, 1'b1);     // zero cycles, nothing moves
      push_tick(8'd0, 1'b0, 1'b0, 1'b0);     // display off, all low
      push_tick(8'd203, 1'b1, 1'b0, 1'b0);   // one short of hblank end
      push_tick(8'd1, 1'b1, 1'b1, 1'b0);     // exact hblank end, line 1 oam
      push_tick(8'd255, 1'b0, 1'b1, 1'b1);   // display off with big count, frozen
      push_tick(8'd79, 1'b1, 1'b0, 1'b1);
      push_tick(8'd1, 1'b1, 1'b1, 1'b1);     // exact oam end
      push_tick(8'd171, 1'b1, 1'b0, 1'b0);
      push_tick(8'd1, 1'b1, 1'b1, 1'b1);     // exact transfer end, render
      push_tick(8'd255, 1'b1, 1'b1, 1'b1);   // overshoot, excess dropped
      push_tick(8'd255, 1'b1, 1'b0, 1'b1);
      push_tick(8'd255, 1'b1, 1'b1, 1'b0);
      push_tick(8'd128, 1'b1, 1'b1, 1'b1);
      push_tick(8'd0, 1'b0, 1'b1, 1'b1);
      push_tick(8'd128, 1'b1, 1'b0, 1'b0);
      push_tick(8'd85, 1'b1, 1'b1, 1'b1);
      push_tick(8'd170, 1'b1, 1'b1, 1'b1);
      wait_drained();

      // random phases; after an unreachable compare (255), it is steered to lines the frame reaches
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: cmp = 8'd255;
            1: cmp = FIRST_VBLANK_LINE;
            2: cmp = 8'd0;
            default: cmp = (tm_line >= 8'd120) ? 8'd0 : tm_line + 8'($urandom_range(1, 30));
         endcase
         write_compare(cmp);
         if (phase == 7) begin
            // closing stretch runs at full rate on both sides
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 50);
            recv_idle_pct = (phase % 3 == 2) ? 0 : $urandom_range(10, 50);
         end
         @(negedge clock);
         lit = 0;
         while (lit < 150) begin
            t = random_tick();
            push_tick(t.cycles, t.display_en, t.ime, t.vbl_ie);
            lit += t.display_en;
         end
         wait_drained();
      end

      // let any stray result show up before the verdict
      repeat (10) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d results never arrived", pending_status.size());
         error_count++;
      end

      $display("ran %0d ticks (%0d with display off) over %0d compare settings",
               ticks_accepted, ticks_dark, compare_writes);
      $display("saw %0d frame wraps, %0d vblank irqs, %0d stat irqs, %0d rendered lines",
               frame_wraps, vblank_irqs, stat_irqs, lines_rendered);
      if (error_count == 0) begin
         $display("lcd_mode_timing_controller_top test passed");
      end else begin
         $display("lcd_mode_timing_controller_top test failed");
      end
      $finish;
   end

endmodule
